### hw/rtl/utf8_byte_decoder_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 byte decoder assertion macros
// Shared concurrent assertion forms for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_BYTE_DECODER_DEFINES_SVH
`define UTF8_BYTE_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8DEC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U8DEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 byte decoder package
// Types, byte range bounds and lead byte classification for the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8dec_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 32;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned CONT_BITS = 6;

  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'd128;
  localparam logic [BYTE_W-1:0] CONT_XOR    = 8'h80;

  typedef enum logic [1:0] {
    LC_ASCII,
    LC_MULTI,
    LC_BAD
  } lead_class_t;

  typedef struct packed {
    lead_class_t             cls;
    logic [LEN_W-1:0]        len;
    logic [BYTE_W-1:0]       payload;
  } lead_info_t;

  function automatic lead_info_t decode_lead(input logic [BYTE_W-1:0] b);
    lead_info_t info;
    info.cls     = LC_BAD;
    info.len     = 3'd1;
    info.payload = '0;
    case (b) inside
      [8'd0:8'd127]: begin
        info.cls     = LC_ASCII;
        info.payload = b;
      end
      [8'd192:8'd223]: begin
        info.cls     = LC_MULTI;
        info.len     = 3'd2;
        info.payload = b & 8'h1F;
      end
      [8'd224:8'd239]: begin
        info.cls     = LC_MULTI;
        info.len     = 3'd3;
        info.payload = b & 8'h0F;
      end
      [8'd240:8'd247]: begin
        info.cls     = LC_MULTI;
        info.len     = 3'd4;
        info.payload = b & 8'h07;
      end
      [8'd248:8'd251]: begin
        info.cls     = LC_MULTI;
        info.len     = 3'd5;
        info.payload = b & 8'h03;
      end
      [8'd252:8'd253]: begin
        info.cls     = LC_MULTI;
        info.len     = 3'd6;
        info.payload = b & 8'h01;
      end
      default: begin
        info.cls     = LC_BAD;
        info.len     = 3'd1;
        info.payload = '0;
      end
    endcase
    return info;
  endfunction

endpackage

### hw/rtl/u8dec_byte_if.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder byte channel
// Valid/ready channel that carries one raw stream byte per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u8dec_byte_if
  import u8dec_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

### hw/rtl/u8dec_cp_if.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder result channel
// Valid/ready channel that carries one decoded code point per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u8dec_cp_if
  import u8dec_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CP_W-1:0]  code_point;
  logic [LEN_W-1:0] seq_length;
  logic             bad_lead;

  modport source (output valid, output code_point, output seq_length, output bad_lead,
                  input ready);
  modport sink   (input valid, input code_point, input seq_length, input bad_lead,
                  output ready);
endinterface

### hw/rtl/utf8_byte_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 byte decoder
// Path: the byte that completes a result passes the input register, then its beat is held in the result register.
// Throughput: one byte per cycle; the input register feeds the decode logic
// and the result register, and both stall only when the result is not taken.
// Reset: synchronous active-low reset empties both registers and returns the
// decoder to idle with a cleared accumulator and a sequence length of one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_byte_decoder_defines.svh"

module utf8_byte_decoder
  import u8dec_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  u8dec_byte_if.sink          in_ch,
  u8dec_cp_if.source          out_ch
);

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;

  logic [CP_W-1:0]   acc_r, acc_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [LEN_W-1:0]  total_r, total_nxt;

  logic              out_valid_r;
  logic [CP_W-1:0]   out_code_r, out_code_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;
  logic              out_bad_r, out_bad_nxt;

  logic              emit;
  logic              out_free;
  logic              s1_fire;
  logic [BYTE_W-1:0] cont_bits;
  lead_info_t        lead;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;

  assign cont_bits = s1_byte_r ^ CONT_XOR;
  assign lead      = decode_lead(s1_byte_r);

  always_comb begin
    acc_nxt      = acc_r;
    left_nxt     = left_r;
    total_nxt    = total_r;
    emit         = 1'b0;
    out_code_nxt = '0;
    out_len_nxt  = 3'd1;
    out_bad_nxt  = 1'b0;
    if (left_r != '0) begin
      acc_nxt      = {acc_r[CP_W-CONT_BITS-1:0], {CONT_BITS{1'b0}}}
                     | {{(CP_W-BYTE_W){1'b0}}, cont_bits};
      left_nxt     = left_r - 3'd1;
      emit         = (left_nxt == '0);
      out_code_nxt = acc_nxt;
      out_len_nxt  = total_r;
    end else begin
      case (lead.cls)
        LC_ASCII: begin
          total_nxt    = 3'd1;
          emit         = 1'b1;
          out_code_nxt = {{(CP_W-BYTE_W){1'b0}}, s1_byte_r};
        end
        LC_MULTI: begin
          acc_nxt   = {{(CP_W-BYTE_W){1'b0}}, lead.payload};
          total_nxt = lead.len;
          left_nxt  = lead.len - 3'd1;
        end
        default: begin
          total_nxt   = 3'd1;
          emit        = 1'b1;
          out_bad_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      left_r      <= '0;
      total_r     <= 3'd1;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_fire && emit;
      end
      if (s1_fire) begin
        acc_r   <= acc_nxt;
        left_r  <= left_nxt;
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.in_byte;
    end
    if (s1_fire && emit) begin
      out_code_r <= out_code_nxt;
      out_len_r  <= out_len_nxt;
      out_bad_r  <= out_bad_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.code_point = out_code_r;
  assign out_ch.seq_length = out_len_r;
  assign out_ch.bad_lead   = out_bad_r;

  `U8DEC_ASSERT_NEXT(a_left_counts_down, clk, rst_n,
    s1_fire && (left_r != '0), left_r == $past(left_r) - 3'd1,
    "continuation count did not step down")
  `U8DEC_ASSERT_NEXT(a_state_holds, clk, rst_n,
    !s1_fire, $stable(left_r) && $stable(acc_r) && $stable(total_r),
    "decoder state changed without a byte")
  `U8DEC_ASSERT_NEXT(a_seq_end_result, clk, rst_n,
    s1_fire && (left_r == 3'd1),
    out_valid_r && !out_bad_r && (out_len_r == $past(total_r)),
    "sequence end did not give a result of the stored length")
  `U8DEC_ASSERT_NEXT(a_ascii_result, clk, rst_n,
    s1_fire && (left_r == '0) && (s1_byte_r < ASCII_LIMIT),
    out_valid_r && (out_code_r == {{(CP_W-BYTE_W){1'b0}}, $past(s1_byte_r)}),
    "idle ASCII byte did not pass through")

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// UTF-8 byte decoder testbench
// Streams directed and random bytes into the decoder through its byte
// channel, predicts every decoded beat, and compares each result beat with
// the oldest prediction while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import u8dec_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_length;
    logic             bad_lead;
  } cp_beat_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    bit                wait_drained;
  } byte_item_t;

  logic clk;
  logic rst_n;

  u8dec_byte_if in_if ();
  u8dec_cp_if   out_if ();

  utf8_byte_decoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  byte_item_t        byte_q[$];
  cp_beat_t          cp_expect_q[$];
  logic [CP_W-1:0]   cp_acc;
  logic [LEN_W-1:0]  cont_left;
  logic [LEN_W-1:0]  seq_total;
  int                gap_left;
  int                stall_left;
  int                n_errors;
  cp_beat_t          got_beat;
  cp_beat_t          want_beat;
  byte_item_t        next_item;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Quiet stretches: the tail of the run and every third window of 100 bytes.
  function automatic bit calm_now();
    return byte_q.size() < 150 || ((byte_q.size() / 100) % 3 == 1);
  endfunction

  function automatic void decode_byte(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] mask;
    len  = '0;
    mask = '0;
    if (cont_left != 0) begin
      cp_acc    = (cp_acc << CONT_BITS) | {{(CP_W-BYTE_W){1'b0}}, b ^ CONT_XOR};
      cont_left = cont_left - 1'b1;
      if (cont_left == 0) begin
        cp_expect_q.push_back('{cp_acc, seq_total, 1'b0});
      end
      return;
    end
    if (b < ASCII_LIMIT) begin
      seq_total = 3'd1;
      cp_expect_q.push_back('{{{(CP_W-BYTE_W){1'b0}}, b}, 3'd1, 1'b0});
      return;
    end
    if (b >= 8'hC0 && b <= 8'hDF) begin
      len = 3'd2; mask = 8'h1F;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      len = 3'd3; mask = 8'h0F;
    end else if (b >= 8'hF0 && b <= 8'hF7) begin
      len = 3'd4; mask = 8'h07;
    end else if (b >= 8'hF8 && b <= 8'hFB) begin
      len = 3'd5; mask = 8'h03;
    end else if (b >= 8'hFC && b <= 8'hFD) begin
      len = 3'd6; mask = 8'h01;
    end else begin
      seq_total = 3'd1;
      cp_expect_q.push_back('{'0, 3'd1, 1'b1});
      return;
    end
    cp_acc    = {{(CP_W-BYTE_W){1'b0}}, b & mask};
    seq_total = len;
    cont_left = len - 1'b1;
  endfunction

  task automatic add_byte(input logic [BYTE_W-1:0] b, input bit drained = 1'b0);
    byte_q.push_back('{b, drained});
  endtask

  task automatic add_sequence(input int len, input bit clean_conts);
    logic [BYTE_W-1:0] lead;
    lead = 8'($urandom);
    case (len)
      1: lead = {1'b0, lead[6:0]};
      2: lead = {3'b110, lead[4:0]};
      3: lead = {4'b1110, lead[3:0]};
      4: lead = {5'b11110, lead[2:0]};
      5: lead = {6'b111110, lead[1:0]};
      default: lead = {7'b1111110, lead[0]};
    endcase
    add_byte(lead);
    for (int i = 1; i < len; i++) begin
      if (clean_conts) begin
        add_byte(8'h80 | 8'($urandom_range(0, 63)));
      end else begin
        add_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int kind;
    int fill_target;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    out_if.ready  = 1'b0;
    rst_n         = 1'b0;
    n_errors      = 0;

    // Extremes of ASCII and of the invalid lead ranges.
    add_byte(8'h00); add_byte(8'h7F); add_byte(8'h80);
    add_byte(8'hBF); add_byte(8'hFE); add_byte(8'hFF);
    // Lead lengths two to five, each with a minimum or maximum payload and continuations.
    add_byte(8'hC0); add_byte(8'h80);
    add_byte(8'hEF); add_byte(8'hBF); add_byte(8'hBF);
    add_byte(8'hF7); add_byte(8'h80); add_byte(8'hBF); add_byte(8'h80);
    add_byte(8'hF8); add_byte(8'hBF); add_byte(8'hBF); add_byte(8'hBF); add_byte(8'hBF);
    // Six-byte sequence whose continuations are ASCII, lead and invalid bytes.
    add_byte(8'hFD); add_byte(8'h00); add_byte(8'h41);
    add_byte(8'hC3); add_byte(8'hFE); add_byte(8'hFF);

    fill_target = byte_q.size() + 1200;
    add_byte(8'h41, 1'b1);
    while (byte_q.size() < fill_target) begin
      if (byte_q.size() > fill_target / 2 && byte_q.size() < fill_target / 2 + 8) begin
        add_byte(8'h20, 1'b1);
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        add_sequence($urandom_range(0, 3) == 0 ? 1 : $urandom_range(2, 6), 1'b1);
      end else if (kind < 82) begin
        add_byte($urandom_range(0, 7) == 0 ? 8'($urandom_range(254, 255))
                                           : 8'($urandom_range(128, 191)));
      end else if (kind < 92) begin
        add_sequence($urandom_range(2, 6), 1'b0);
      end else begin
        add_byte(8'($urandom_range(0, 255)));
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0) @(posedge clk);
    @(posedge clk);
    while (in_if.valid) @(posedge clk);
    while (cp_expect_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Byte driver: holds a beat until it is taken, then predicts its effect.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.in_byte <= '0;
      gap_left      <= 0;
      cp_acc         = '0;
      cont_left      = '0;
      seq_total      = 3'd1;
    end else begin
      if (in_if.valid && in_if.ready) begin
        decode_byte(in_if.in_byte);
      end
      if (in_if.valid && !in_if.ready) begin
        // The beat stays on the channel.
      end else if (gap_left > 0) begin
        gap_left    <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (byte_q.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (byte_q[0].wait_drained && cp_expect_q.size() != 0) begin
        in_if.valid <= 1'b0;
      end else if (!calm_now() && $urandom_range(0, 5) == 0) begin
        gap_left    <= $urandom_range(0, 6);
        in_if.valid <= 1'b0;
      end else begin
        next_item      = byte_q.pop_front();
        in_if.valid   <= 1'b1;
        in_if.in_byte <= next_item.data;
      end
    end
  end

  // Result monitor: stalls in bursts and checks every taken beat in order.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_beat = {out_if.code_point, out_if.seq_length, out_if.bad_lead};
        if (cp_expect_q.size() == 0) begin
          n_errors++;
          $display("%0t: expected no beat, got cp=%h len=%0d bad=%0b", $time,
                   got_beat.code_point, got_beat.seq_length, got_beat.bad_lead);
        end else begin
          want_beat = cp_expect_q.pop_front();
          if (got_beat.code_point !== want_beat.code_point ||
              got_beat.seq_length !== want_beat.seq_length ||
              got_beat.bad_lead !== want_beat.bad_lead) begin
            n_errors++;
            $display("%0t: expected cp=%h len=%0d bad=%0b, got cp=%h len=%0d bad=%0b",
                     $time, want_beat.code_point, want_beat.seq_length,
                     want_beat.bad_lead, got_beat.code_point, got_beat.seq_length,
                     got_beat.bad_lead);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else if (!calm_now() && $urandom_range(0, 5) == 0) begin
        stall_left   <= $urandom_range(0, 6);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

endmodule
